>>> sv/bcrr_pkg.sv
// Package for the block cache with random replacement: types and codes.
package bcrr_pkg;

  localparam int unsigned SlotW   = 6;
  localparam int unsigned DrawLim = 64;

  typedef enum logic [1:0] {
    CMD_ACCESS = 2'd0,
    CMD_FDONE  = 2'd1,
    CMD_RDONE  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_FETCH  = 2'd0,
    KIND_GRANT  = 2'd1,
    KIND_REFUSE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    REG_SLOT_COUNT = 2'd0,
    REG_FILE_LIMIT = 2'd1
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SCAN,
    ST_SCAN_END,
    ST_FREE,
    ST_DRAW,
    ST_WALK,
    ST_CLAIM,
    ST_GRANT_SET,
    ST_OUT,
    ST_NEXT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture the input item
    logic flag_clear;  // apply fetch/read done
    logic scan_start;  // reset scan index (lookup / free check)
    logic scan_step;   // advance scan index
    logic take_hit;    // lookup found the block at the scanned slot
    logic draw;        // advance LFSR, check drawn slot
    logic walk;        // advance wrap-around walk
    logic claim;       // claim victim, emit fetch request
    logic set_read;    // mark granted slot reading
    logic use_next;    // switch to next block
    logic out_grant;   // emit grant
    logic out_refuse;  // emit refusal
  } cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic [1:0] cmd;
    logic       scan_done;
    logic       match;     // scanned slot holds the block
    logic       free;      // scanned slot below count is unpinned
    logic       draw_ok;   // drawn / walked slot unpinned
    logic       draws_out; // draw limit reached
    logic       in_file;   // block below file limit
    logic       has_next;  // next block is eligible
    logic       on_next;   // working on prefetch
    logic       out_busy;  // output register full and not taken
  } stat_t;

endpackage

>>> sv/bcrr_ctrl.sv
// Controller state machine of the block cache.
module bcrr_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  bcrr_pkg::stat_t st_i,
  output bcrr_pkg::cmd_t  cmd_o
);
  import bcrr_pkg::*;

  state_e state_q, state_d;
  logic   hit_q, hit_d;  // access holds a slot (hit or fetched)

  // Next state.
  always_comb begin
    state_d = state_q;
    hit_d   = hit_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (st_i.cmd == CMD_ACCESS) state_d = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        if (!st_i.on_next) hit_d = 1'b0;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (st_i.match) begin
          hit_d   = 1'b1;
          state_d = st_i.on_next ? ST_OUT : ST_GRANT_SET;
        end else if (st_i.scan_done) begin
          state_d = ST_SCAN_END;
        end
      end
      ST_SCAN_END: state_d = ST_FREE;
      ST_FREE: begin
        if (st_i.free && st_i.in_file) state_d = ST_DRAW;
        else if (st_i.scan_done || !st_i.in_file) begin
          state_d = st_i.on_next ? ST_OUT : ST_OUT;
        end
      end
      ST_DRAW: begin
        if (st_i.draw_ok) state_d = ST_CLAIM;
        else if (st_i.draws_out) state_d = ST_WALK;
      end
      ST_WALK: if (st_i.draw_ok) state_d = ST_CLAIM;
      ST_CLAIM: begin
        if (!st_i.out_busy) begin
          hit_d   = 1'b1;
          state_d = st_i.on_next ? ST_OUT : ST_GRANT_SET;
        end
      end
      ST_GRANT_SET: state_d = st_i.has_next ? ST_NEXT : ST_OUT;
      ST_NEXT: state_d = ST_CLEAR;
      ST_OUT: if (!st_i.out_busy) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load      = in_valid_i;
        cmd_o.flag_clear = in_valid_i;
      end
      ST_CLEAR:  cmd_o.scan_start = 1'b1;
      ST_SCAN: begin
        cmd_o.scan_step = !st_i.match;
        cmd_o.take_hit  = st_i.match;
      end
      ST_SCAN_END: cmd_o.scan_start = 1'b1;
      ST_FREE:   cmd_o.scan_step = !st_i.free;
      ST_DRAW:   cmd_o.draw = !st_i.draw_ok;
      ST_WALK:   cmd_o.walk = !st_i.draw_ok;
      ST_CLAIM:  cmd_o.claim = !st_i.out_busy;
      ST_GRANT_SET: cmd_o.set_read = 1'b1;
      ST_NEXT:   cmd_o.use_next = 1'b1;
      ST_OUT: begin
        cmd_o.out_grant  = !st_i.out_busy && (hit_q || st_i.on_next);
        cmd_o.out_refuse = !st_i.out_busy && !hit_q && !st_i.on_next;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      hit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      hit_q   <= hit_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == ST_IDLE) else $error("ready outside idle");
  a_claim_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLAIM && st_i.out_busy) |=> state_q == ST_CLAIM)
    else $error("claim lost");
  a_out_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && !st_i.out_busy) |=> state_q == ST_IDLE)
    else $error("out did not finish");
`endif

endmodule

>>> sv/bcrr_dp.sv
// Datapath of the block cache: slot flags, owner memory, LFSR, output register.
module bcrr_dp #(
  parameter int unsigned NumSlots = 64,
  parameter int unsigned BlkW     = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bcrr_pkg::cmd_t        cmd_i,
  output bcrr_pkg::stat_t       st_o,
  input  logic [1:0]            command_i,
  input  logic [31:0]           file_block_i,
  input  logic                  past_half_i,
  input  logic [5:0]            slot_index_i,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [31:0]           cfg_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            kind_o,
  output logic [31:0]           block_number_o,
  output logic [5:0]            slot_number_o,
  output logic                  was_hit_o,
  output logic                  must_wait_o,
  output logic                  last_o
);
  import bcrr_pkg::*;

  localparam int unsigned IdxW = (NumSlots > 1) ? $clog2(NumSlots) : 1;
  localparam int unsigned CntW = $clog2(NumSlots + 1);
  localparam logic [BlkW-1:0] BlkMax = {BlkW{1'b1}};

  logic [NumSlots-1:0] unused_q, reading_q, fetching_q;
  logic [BlkW-1:0]     owner_mem [NumSlots];
  logic [BlkW-1:0]     owner_rd_q;
  logic [31:0]         lfsr_q, lfsr_d;
  logic [6:0]          cnt_cfg_q;
  logic [31:0]         limit_q;
  logic [BlkW-1:0]     blk_q, orig_q;
  logic                half_q, on_next_q;
  logic [CntW-1:0]     scan_q;   // address being read (one ahead of data)
  logic [IdxW-1:0]     chk_q;    // slot whose owner is in owner_rd_q
  logic                chk_v_q;
  logic [IdxW-1:0]     vic_q, grant_q;
  logic [6:0]          draws_q;
  logic [CntW-1:0]     n_act;
  logic [31:0]         draw_val;
  logic [IdxW-1:0]     draw_slot;
  logic [IdxW-1:0]     walk_slot;
  logic [NumSlots-1:0] pinned;
  logic                ov_q;
  logic [1:0]          kind_q;
  logic [31:0]         obn_q;
  logic [5:0]          osl_q;
  logic                ohit_q, owait_q, olast_q;
  logic                hit_orig_q;

  assign pinned = reading_q | fetching_q;

  // Active slot count with clamping.
  always_comb begin
    if (cnt_cfg_q == '0) n_act = CntW'(1);
    else if (32'(cnt_cfg_q) > NumSlots) n_act = CntW'(NumSlots);
    else n_act = CntW'(cnt_cfg_q);
  end

  // LFSR step; the draw is reduced by the modulo unit below.
  always_comb begin
    lfsr_d = lfsr_q[0] ? ((lfsr_q >> 1) ^ 32'hD000_0001) : (lfsr_q >> 1);
  end

  // Modulo unit: iterative remainder of lfsr_d by n_act, one bit a cycle.
  logic [5:0]        mod_bit_q;
  logic [31:0]       mod_rem_q, mod_src_q;
  logic              mod_busy_q, mod_done_q;
  logic [32:0]       mod_try;
  assign mod_try = {mod_rem_q, mod_src_q[31]} - 33'(n_act);
  assign draw_val = mod_rem_q;
  assign draw_slot = IdxW'(mod_rem_q);

  always_comb begin
    if ({1'b0, vic_q} + 1'b1 >= (IdxW+1)'(n_act)) walk_slot = '0;
    else walk_slot = vic_q + 1'b1;
  end

  // Status.
  always_comb begin
    st_o           = '0;
    st_o.cmd       = command_i;
    st_o.scan_done = (scan_q >= CntW'(NumSlots)) && chk_v_q == 1'b0;
    st_o.match     = chk_v_q && !unused_q[chk_q] && owner_rd_q == blk_q;
    st_o.free      = chk_v_q && (CntW'(chk_q) < n_act) && !pinned[chk_q];
    st_o.draw_ok   = mod_done_q ? !pinned[draw_slot] : 1'b0;
    st_o.draws_out = mod_done_q && (draws_q >= 7'(DrawLim));
    st_o.in_file   = 32'(blk_q) < limit_q;
    st_o.has_next  = half_q && (orig_q != BlkMax);
    st_o.on_next   = on_next_q;
    st_o.out_busy  = ov_q && !out_ready_i;
  end

  // Input capture, config, scan, draw and flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unused_q   <= '1;
      reading_q  <= '0;
      fetching_q <= '0;
      lfsr_q     <= 32'd1;
      cnt_cfg_q  <= 7'd64;
      limit_q    <= '0;
      on_next_q  <= 1'b0;
      scan_q     <= '0;
      chk_q      <= '0;
      chk_v_q    <= 1'b0;
      vic_q      <= '0;
      grant_q    <= '0;
      draws_q    <= '0;
      mod_bit_q  <= '0;
      mod_rem_q  <= '0;
      mod_src_q  <= '0;
      mod_busy_q <= 1'b0;
      mod_done_q <= 1'b0;
      ov_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == 1'(REG_SLOT_COUNT)) cnt_cfg_q <= cfg_data_i[6:0];
        else limit_q <= cfg_data_i;
      end
      if (cmd_i.load) begin
        on_next_q <= 1'b0;
      end
      if (cmd_i.flag_clear && (32'(slot_index_i) < NumSlots)) begin
        if (command_i == CMD_FDONE) fetching_q[IdxW'(slot_index_i)] <= 1'b0;
        if (command_i == CMD_RDONE) reading_q[IdxW'(slot_index_i)] <= 1'b0;
      end
      // sequential scan: address scan_q, data arrives next cycle
      if (cmd_i.scan_start) begin
        scan_q  <= CntW'(1);
        chk_q   <= '0;
        chk_v_q <= 1'b1;
        draws_q <= '0;
        mod_busy_q <= 1'b0;
        mod_done_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        chk_v_q <= scan_q < CntW'(NumSlots);
        chk_q   <= IdxW'(scan_q);
        scan_q  <= scan_q + 1'b1;
      end
      // lookup hit of the original access records the granted slot
      if (cmd_i.take_hit && !on_next_q) grant_q <= chk_q;
      // draw: start LFSR step and run the remainder unit
      if (cmd_i.draw) begin
        if (!mod_busy_q) begin
          lfsr_q     <= lfsr_d;
          mod_src_q  <= lfsr_d;
          mod_rem_q  <= '0;
          mod_bit_q  <= '0;
          mod_busy_q <= 1'b1;
          mod_done_q <= 1'b0;
          draws_q    <= draws_q + 1'b1;
        end else if (!mod_done_q) begin
          if (!mod_try[32]) mod_rem_q <= mod_try[31:0];
          else mod_rem_q <= {mod_rem_q[30:0], mod_src_q[31]};
          mod_src_q <= mod_src_q << 1;
          mod_bit_q <= mod_bit_q + 1'b1;
          if (mod_bit_q == 6'd31) mod_done_q <= 1'b1;
        end else begin
          // last draw pinned: keep it for the walk, or draw again
          vic_q <= draw_slot;
          if (draws_q < 7'(DrawLim)) mod_busy_q <= 1'b0;
          mod_done_q <= draws_q >= 7'(DrawLim);
        end
      end
      if (cmd_i.walk) begin
        vic_q     <= walk_slot;
        mod_rem_q <= 32'(walk_slot);
      end
      if (cmd_i.claim) begin
        fetching_q[draw_slot] <= 1'b1;
        unused_q[draw_slot]   <= 1'b0;
        grant_q               <= on_next_q ? grant_q : draw_slot;
      end
      if (cmd_i.set_read) reading_q[grant_q] <= 1'b1;
      if (cmd_i.use_next) on_next_q <= 1'b1;
      // output register
      if (ov_q && out_ready_i) ov_q <= 1'b0;
      if (cmd_i.claim || cmd_i.out_grant || cmd_i.out_refuse) ov_q <= 1'b1;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      blk_q  <= BlkW'(file_block_i);
      orig_q <= BlkW'(file_block_i);
      half_q <= past_half_i;
    end
    if (cmd_i.use_next) blk_q <= orig_q + 1'b1;
    if (cmd_i.claim) begin
      kind_q  <= KIND_FETCH;
      obn_q   <= 32'(blk_q);
      osl_q   <= 6'(draw_slot);
      ohit_q  <= 1'b0;
      owait_q <= 1'b0;
      olast_q <= 1'b0;
    end
    if (cmd_i.out_grant) begin
      kind_q  <= KIND_GRANT;
      obn_q   <= 32'(orig_q);
      osl_q   <= 6'(grant_q);
      ohit_q  <= hit_orig_q;
      owait_q <= fetching_q[grant_q];
      olast_q <= 1'b1;
    end
    if (cmd_i.out_refuse) begin
      kind_q  <= KIND_REFUSE;
      obn_q   <= 32'(orig_q);
      osl_q   <= '0;
      ohit_q  <= 1'b0;
      owait_q <= 1'b0;
      olast_q <= 1'b1;
    end
  end

  // Hit flag of the original access.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) hit_orig_q <= 1'b0;
    else if (cmd_i.take_hit && !on_next_q) hit_orig_q <= 1'b1;
  end

  // Owner memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.claim) owner_mem[draw_slot] <= blk_q;
    owner_rd_q <= owner_mem[cmd_i.scan_start ? '0 : IdxW'(scan_q)];
  end

  assign out_valid_o    = ov_q;
  assign kind_o         = kind_q;
  assign block_number_o = obn_q;
  assign slot_number_o  = osl_q;
  assign was_hit_o      = ohit_q;
  assign must_wait_o    = owait_q;
  assign last_o         = olast_q;

`ifndef NO_ASSERTIONS
  a_lfsr_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lfsr_q != '0) else $error("lfsr stuck at zero");
  a_claim_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.claim |-> !pinned[draw_slot]) else $error("claimed a pinned slot");
  a_draw_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mod_done_q && cmd_i.claim) |-> draw_val < 32'(n_act))
    else $error("victim out of range");
`endif

endmodule

>>> sv/block_cache_random_replace.sv
// Top level of the fully associative block cache with random replacement.
//
// Input channel (in_valid_i/in_ready_o) carries one command item: access a
// file block, fetch completed, or reading finished. Output channel
// (out_valid_o/out_ready_i) carries result items: up to two fetch requests,
// then a grant or refusal; last_o marks the final result of an access.
// Items are handled one at a time; in_ready_o is high only while idle.
// Done commands produce no result and are applied in the accepting cycle.
// An access scans all slots for the block through the single owner memory
// read port; a miss adds a scan for a free slot and up to 64 victim draws
// in the iterative remainder unit, then a wrap-around walk if all of them
// hit pinned slots. A prefetch of the next block repeats this work.
// Configuration writes (slot count, file block limit) are to be made only
// while idle; the block itself does not enforce this. Reset marks all
// slots unused, clears the reading and fetching flags, sets slot count 64,
// file limit 0 and the LFSR to one. A stalled receiver holds the controller
// in its emitting state; no result is lost.
module block_cache_random_replace #(
  parameter int unsigned NUM_SLOTS      = 64,
  parameter int unsigned BLOCK_NUM_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [31:0] file_block_i,
  input  logic        past_half_i,
  input  logic [5:0]  slot_index_i,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [31:0] block_number_o,
  output logic [5:0]  slot_number_o,
  output logic        was_hit_o,
  output logic        must_wait_o,
  output logic        last_o
);
  import bcrr_pkg::*;

  cmd_t  cmd;
  stat_t st;

  bcrr_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .st_i(st), .cmd_o(cmd)
  );

  bcrr_dp #(.NumSlots(NUM_SLOTS), .BlkW(BLOCK_NUM_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .st_o(st),
    .command_i, .file_block_i, .past_half_i, .slot_index_i,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .out_valid_o, .out_ready_i, .kind_o, .block_number_o, .slot_number_o,
    .was_hit_o, .must_wait_o, .last_o
  );

endmodule
